// File: rtl/hsi2rgbw_pkg.sv
// Shared constants, field widths and the hue-ratio lookup table for the HSI to RGBW converter.
// No dependencies; imported by the channel interfaces and by hsi_to_rgbw_convert.
`default_nettype none

package hsi2rgbw_pkg;

	// Field widths of the pixel channels
	localparam int HUE_W   = 9;
	localparam int SAT_W   = 9;
	localparam int INT_W   = 10;
	localparam int LEVEL_W = 8;

	// Fractional bits of the sector ratio q = cos(d)/cos(60-d)
	localparam int RATIO_FRAC_BITS = 16;

	// Angle and level constants
	localparam int unsigned DEG_FULL   = 360;
	localparam int unsigned DEG_SECTOR = 120;
	localparam int unsigned DEG_HALF   = 180;
	localparam int unsigned DEG_SIXTY  = 60;

	localparam logic [HUE_W-1:0] HUE_FULL    = HUE_W'(DEG_FULL);
	localparam logic [HUE_W-1:0] HUE_SECTOR1 = HUE_W'(DEG_SECTOR);
	localparam logic [HUE_W-1:0] HUE_SECTOR2 = HUE_W'(2 * DEG_SECTOR);

	localparam logic [SAT_W-1:0] SAT_MAX   = SAT_W'(256);
	localparam logic [INT_W-1:0] INT_MAX   = INT_W'(512);
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(255);

	// Offset inside a 120-degree sector
	localparam int OFFSET_W = $clog2(DEG_SECTOR);

	// Signed ratio: magnitude up to about 2.0, so two integer bits and a sign
	localparam int RATIO_W  = RATIO_FRAC_BITS + 3;
	// Channel factors 1+q and 2-q stay below 4.0 and are never negative
	localparam int FACTOR_W = RATIO_FRAC_BITS + 2;

	// S*I and (256-S)*I are at most 2^17
	localparam int SI_W    = 18;
	// S*I*255
	localparam int SI255_W = 25;
	// S*I*255*factor
	localparam int PROD_W  = SI255_W + FACTOR_W;
	// Product after dropping 2^(16+RATIO_FRAC_BITS); still to be divided by 3
	localparam int QUOT_SHIFT = 16 + RATIO_FRAC_BITS;
	localparam int QUOT_W     = PROD_W - QUOT_SHIFT;
	// floor(v/3) for v < 768 is (v*683) >> 11
	localparam int DIV3_IN_W  = 10;
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;
	localparam int DIV3_PROD_W = DIV3_IN_W + 10;
	localparam logic [QUOT_W-1:0] QUOT_SAT = QUOT_W'(3 * 256);

	// White: 255*(256-S)*I >> 16
	localparam int WHITE_SHIFT = 16;
	localparam int WHITE_W     = SI255_W - WHITE_SHIFT;

	localparam logic signed [RATIO_W:0] RATIO_ONE = (RATIO_W+1)'(64'd1 << RATIO_FRAC_BITS);
	localparam logic signed [RATIO_W:0] RATIO_TWO = (RATIO_W+1)'(64'd2 << RATIO_FRAC_BITS);

	// Which two colour channels a hue sector drives
	typedef enum logic [1:0] {
		SECTOR_RG = 2'd0,
		SECTOR_GB = 2'd1,
		SECTOR_BR = 2'd2
	} sector_t;

	// Series constants used only while building the table
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;
	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam int unsigned SERIES_TERMS = 12;

	typedef logic [DEG_SECTOR-1:0][RATIO_W-1:0] ratio_table_t;

	// Unsigned 64-bit quotient by restoring long division, table build only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, dvs}) begin
				rem    = rem - {1'b0, dvs};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// cos(deg) in Q.30 by a truncated Taylor series
	function automatic logic signed [63:0] cos_deg_q30(input int unsigned deg);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        t;
		logic [63:0]        den;
		logic signed [63:0] acc;
		x   = udiv64(64'(deg) * PI_Q30 + 64'(DEG_HALF / 2), 64'(DEG_HALF));
		x2  = (x * x) >> 30;
		t   = ONE_Q30;
		acc = signed'(ONE_Q30);
		for (int unsigned k = 1; k <= SERIES_TERMS; k++) begin
			den = 64'((2 * k - 1) * (2 * k));
			t   = udiv64((t * x2) >> 30, den);
			if (k[0]) begin
				acc = acc - signed'(t);
			end else begin
				acc = acc + signed'(t);
			end
		end
		return acc;
	endfunction

	// q(d) = cos(d)/cos(|60-d|), rounded half away from zero
	function automatic logic signed [RATIO_W-1:0] ratio_q(input int unsigned d);
		logic signed [63:0] c;
		logic signed [63:0] den;
		logic [63:0]        mag;
		logic [63:0]        uden;
		logic [63:0]        q;
		c   = cos_deg_q30(d);
		den = cos_deg_q30((d <= DEG_SIXTY) ? (DEG_SIXTY - d) : (d - DEG_SIXTY));
		if (den <= 0) begin
			den = 64'sd1;
		end
		uden = unsigned'(den);
		mag  = (c < 0) ? unsigned'(-c) : unsigned'(c);
		q    = udiv64((mag << RATIO_FRAC_BITS) + (uden >> 1), uden);
		return (c < 0) ? RATIO_W'(-signed'(q)) : RATIO_W'(q);
	endfunction

	function automatic ratio_table_t build_ratio_table();
		ratio_table_t tbl;
		for (int unsigned d = 0; d < DEG_SECTOR; d++) begin
			tbl[d] = ratio_q(d);
		end
		return tbl;
	endfunction

	// Constant ROM, evaluated at elaboration
	localparam ratio_table_t RATIO_TABLE = build_ratio_table();

endpackage

`default_nettype wire

// File: rtl/hsi2rgbw_in_if.sv
// Input pixel channel: valid/ready handshake with an HSI colour payload.
// Depends on hsi2rgbw_pkg for field widths.
`default_nettype none

interface hsi2rgbw_in_if;
	import hsi2rgbw_pkg::*;

	logic             valid;
	logic             ready;
	logic [HUE_W-1:0] hue_deg;
	logic [SAT_W-1:0] saturation;
	logic [INT_W-1:0] intensity;

	modport source (output valid, output hue_deg, output saturation, output intensity,
		input ready);
	modport sink (input valid, input hue_deg, input saturation, input intensity,
		output ready);
endinterface

`default_nettype wire

// File: rtl/hsi2rgbw_out_if.sv
// Output pixel channel: valid/ready handshake with RGBW drive levels.
// Depends on hsi2rgbw_pkg for field widths.
`default_nettype none

interface hsi2rgbw_out_if;
	import hsi2rgbw_pkg::*;

	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] red;
	logic [LEVEL_W-1:0] green;
	logic [LEVEL_W-1:0] blue;
	logic [LEVEL_W-1:0] white;

	modport source (output valid, output red, output green, output blue, output white,
		input ready);
	modport sink (input valid, input red, input green, input blue, input white,
		output ready);
endinterface

`default_nettype wire

// File: rtl/hsi_to_rgbw_convert.sv
// HSI to RGBW converter, five-stage pipeline from pixel_in to pixel_out.
// Depends on hsi2rgbw_pkg, hsi2rgbw_in_if and hsi2rgbw_out_if.
`default_nettype none

// Converts one hue/saturation/intensity colour per transfer into red, green, blue and
// white drive bytes. Hue is in whole degrees (values of 360 and above wrap once),
// saturation is Q1.8 clamped to 1.0, intensity is Q2.8 clamped to 2.0. The hue picks a
// 120-degree sector; the offset in it reads a constant table of cos(d)/cos(60-d), and the
// two active channels get S*I*255/3*(1+q) and S*I*255/3*(2-q), the third zero. White is
// 255*(1-S)*I. All levels truncate and saturate at 255. A result is registered in stages
// 1 to 5 in turn and is valid at pixel_out from the stage 5 register; throughput is one
// colour per cycle while the output is not stalled, set by the five pipeline registers,
// which all advance together whenever the output is not stalled. A stage moves on when
// the stage after it is empty or moving, so bubbles close up and pixel_in stays ready
// while a finished result waits at pixel_out, as long as some stage has room.

module hsi_to_rgbw_convert (
	input  wire logic     clk,
	input  wire logic     arst_n,
	hsi2rgbw_in_if.sink   pixel_in,
	hsi2rgbw_out_if.source pixel_out
);
	import hsi2rgbw_pkg::*;

	// Stage valids and advance enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	// Stage 1: wrapped hue split into sector and offset, clamped S and I
	logic [HUE_W-1:0]    hue_wrap;
	sector_t             sector_in;
	logic [HUE_W-1:0]    offset_wide;
	sector_t             sector_s1;
	logic [OFFSET_W-1:0] offset_s1;
	logic [SAT_W-1:0]    sat_s1;
	logic [INT_W-1:0]    int_s1;

	// Stage 2: channel factors and the two S/I products
	logic signed [RATIO_W-1:0] ratio;
	logic signed [RATIO_W:0]   up_full;
	logic signed [RATIO_W:0]   down_full;
	logic [FACTOR_W-1:0]       up_fac;
	logic [FACTOR_W-1:0]       down_fac;
	sector_t                   sector_s2;
	logic [FACTOR_W-1:0]       up_s2;
	logic [FACTOR_W-1:0]       down_s2;
	logic [SI_W-1:0]           si_s2;
	logic [SI_W-1:0]           ws_s2;

	// Stage 3: times 255, white finished
	logic [SI255_W-1:0]  si255;
	logic [SI255_W-1:0]  ws255;
	logic [WHITE_W-1:0]  white_raw;
	sector_t             sector_s3;
	logic [FACTOR_W-1:0] up_s3;
	logic [FACTOR_W-1:0] down_s3;
	logic [SI255_W-1:0]  si255_s3;
	logic [LEVEL_W-1:0]  white_s3;

	// Stage 4: full colour products
	sector_t            sector_s4;
	logic [PROD_W-1:0]  prod_a_s4;
	logic [PROD_W-1:0]  prod_b_s4;
	logic [LEVEL_W-1:0] white_s4;

	// Stage 5: divide by 3, saturate, route to channels
	logic [QUOT_W-1:0]       quot_a;
	logic [QUOT_W-1:0]       quot_b;
	logic [DIV3_PROD_W-1:0]  div_a;
	logic [DIV3_PROD_W-1:0]  div_b;
	logic [LEVEL_W-1:0]      level_a;
	logic [LEVEL_W-1:0]      level_b;
	logic [LEVEL_W-1:0]      red_s5, green_s5, blue_s5, white_s5;

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		en_s5 = !valid_s5 || pixel_out.ready;
		en_s4 = !valid_s4 || en_s5;
		en_s3 = !valid_s3 || en_s4;
		en_s2 = !valid_s2 || en_s3;
		en_s1 = !valid_s1 || en_s2;
	end

	assign pixel_in.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= pixel_in.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	// ---- Stage 1 ----
	// Wrap out-of-range hue once, then find the sector by two compares
	always_comb begin
		hue_wrap = (pixel_in.hue_deg >= HUE_FULL) ? (pixel_in.hue_deg - HUE_FULL)
			: pixel_in.hue_deg;
		if (hue_wrap < HUE_SECTOR1) begin
			sector_in   = SECTOR_RG;
			offset_wide = hue_wrap;
		end else if (hue_wrap < HUE_SECTOR2) begin
			sector_in   = SECTOR_GB;
			offset_wide = hue_wrap - HUE_SECTOR1;
		end else begin
			sector_in   = SECTOR_BR;
			offset_wide = hue_wrap - HUE_SECTOR2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sector_s1 <= sector_in;
			offset_s1 <= offset_wide[OFFSET_W-1:0];
			sat_s1    <= (pixel_in.saturation > SAT_MAX) ? SAT_MAX : pixel_in.saturation;
			int_s1    <= (pixel_in.intensity > INT_MAX) ? INT_MAX : pixel_in.intensity;
		end
	end

	// ---- Stage 2 ----
	// Look up q, form 1+q and 2-q; drop a factor that is zero or negative
	always_comb begin
		ratio     = signed'(RATIO_TABLE[offset_s1]);
		up_full   = RATIO_ONE + {ratio[RATIO_W-1], ratio};
		down_full = RATIO_TWO - {ratio[RATIO_W-1], ratio};
		up_fac    = (up_full <= 0) ? '0 : up_full[FACTOR_W-1:0];
		down_fac  = (down_full <= 0) ? '0 : down_full[FACTOR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sector_s2 <= sector_s1;
			up_s2     <= up_fac;
			down_s2   <= down_fac;
			si_s2     <= SI_W'(sat_s1) * SI_W'(int_s1);
			ws_s2     <= SI_W'(SAT_MAX - sat_s1) * SI_W'(int_s1);
		end
	end

	// ---- Stage 3 ----
	// Multiply by 255 as x*256 - x; white is complete here
	always_comb begin
		si255     = (SI255_W'(si_s2) << LEVEL_W) - SI255_W'(si_s2);
		ws255     = (SI255_W'(ws_s2) << LEVEL_W) - SI255_W'(ws_s2);
		white_raw = ws255[SI255_W-1:WHITE_SHIFT];
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			sector_s3 <= sector_s2;
			up_s3     <= up_s2;
			down_s3   <= down_s2;
			si255_s3  <= si255;
			white_s3  <= (white_raw > WHITE_W'(LEVEL_MAX)) ? LEVEL_MAX
				: white_raw[LEVEL_W-1:0];
		end
	end

	// ---- Stage 4 ----
	always_ff @(posedge clk) begin
		if (en_s4) begin
			sector_s4 <= sector_s3;
			prod_a_s4 <= PROD_W'(si255_s3) * PROD_W'(up_s3);
			prod_b_s4 <= PROD_W'(si255_s3) * PROD_W'(down_s3);
			white_s4  <= white_s3;
		end
	end

	// ---- Stage 5 ----
	// Drop the fixed-point scale, then divide by 3 by reciprocal; anything at or
	// above 3*256 saturates, so the reciprocal only sees values below 768
	always_comb begin
		quot_a  = prod_a_s4[PROD_W-1:QUOT_SHIFT];
		quot_b  = prod_b_s4[PROD_W-1:QUOT_SHIFT];
		div_a   = DIV3_PROD_W'(quot_a[DIV3_IN_W-1:0]) * DIV3_PROD_W'(DIV3_MUL);
		div_b   = DIV3_PROD_W'(quot_b[DIV3_IN_W-1:0]) * DIV3_PROD_W'(DIV3_MUL);
		level_a = (quot_a >= QUOT_SAT) ? LEVEL_MAX : div_a[DIV3_SHIFT +: LEVEL_W];
		level_b = (quot_b >= QUOT_SAT) ? LEVEL_MAX : div_b[DIV3_SHIFT +: LEVEL_W];
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			case (sector_s4)
				SECTOR_RG: begin
					red_s5   <= level_a;
					green_s5 <= level_b;
					blue_s5  <= '0;
				end
				SECTOR_GB: begin
					red_s5   <= '0;
					green_s5 <= level_a;
					blue_s5  <= level_b;
				end
				SECTOR_BR: begin
					red_s5   <= level_b;
					green_s5 <= '0;
					blue_s5  <= level_a;
				end
				default: begin
					red_s5   <= '0;
					green_s5 <= '0;
					blue_s5  <= '0;
				end
			endcase
			white_s5 <= white_s4;
		end
	end

	assign pixel_out.valid = valid_s5;
	assign pixel_out.red   = red_s5;
	assign pixel_out.green = green_s5;
	assign pixel_out.blue  = blue_s5;
	assign pixel_out.white = white_s5;

endmodule

`default_nettype wire
